FILE: rtl/csvtok_pkg.sv
package csvtok_pkg;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;

   localparam logic [7:0] DELIM_RESET = 8'd44;

   localparam logic CMD_DATA = 1'b0;
   localparam logic CMD_END  = 1'b1;

   localparam logic [2:0] KIND_CONTENT = 3'd0;
   localparam logic [2:0] KIND_FIELD   = 3'd1;
   localparam logic [2:0] KIND_ROW     = 3'd2;
   localparam logic [2:0] KIND_FINAL   = 3'd3;
   localparam logic [2:0] KIND_ERROR   = 3'd4;

   typedef struct packed {
      logic       command;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [2:0] token_kind;
      logic [7:0] out_byte;
   } rsp_type;

   typedef struct packed {
      logic inside_quotes;
      logic quote_pending;
      logic skip_line_feed;
   } flags_type;

endpackage

FILE: rtl/csvtok_step.sv
module csvtok_step (
   input  csvtok_pkg::flags_type flags,
   input  logic [7:0]            delimiter,
   input  csvtok_pkg::req_type   req,
   output csvtok_pkg::flags_type flags_next,
   output logic                  emit,
   output csvtok_pkg::rsp_type   rsp
);
   import csvtok_pkg::*;

   always_comb begin
      flags_type  f;
      logic       done;
      logic [7:0] c;
      f    = flags;
      done = 1'b0;
      c    = req.data_byte;
      emit = 1'b0;
      rsp  = '0;
      if (req.command == CMD_END) begin
         // a pending quote closes quoting before the open check
         emit           = 1'b1;
         rsp.token_kind = (flags.inside_quotes && !flags.quote_pending) ? KIND_ERROR
                                                                         : KIND_FINAL;
         f              = '0;
      end else begin
         if (f.quote_pending) begin
            f.quote_pending = 1'b0;
            if (c == CH_QUOTE) begin
               emit           = 1'b1;
               rsp.token_kind = KIND_CONTENT;
               rsp.out_byte   = CH_QUOTE;
               done           = 1'b1;
            end else begin
               f.inside_quotes = 1'b0;
            end
         end
         if (!done && f.skip_line_feed) begin
            f.skip_line_feed = 1'b0;
            if (c == CH_LF) begin
               done = 1'b1;
            end
         end
         if (!done) begin
            if (c == CH_QUOTE) begin
               if (f.inside_quotes) begin
                  f.quote_pending = 1'b1;
               end else begin
                  f.inside_quotes = 1'b1;
               end
            end else if (!f.inside_quotes && c == delimiter) begin
               emit           = 1'b1;
               rsp.token_kind = KIND_FIELD;
            end else if (!f.inside_quotes && c == CH_LF) begin
               emit           = 1'b1;
               rsp.token_kind = KIND_ROW;
            end else if (!f.inside_quotes && c == CH_CR) begin
               f.skip_line_feed = 1'b1;
               emit             = 1'b1;
               rsp.token_kind   = KIND_ROW;
            end else begin
               emit           = 1'b1;
               rsp.token_kind = KIND_CONTENT;
               rsp.out_byte   = c;
            end
         end
      end
      flags_next = f;
   end

endmodule

FILE: rtl/csvtok_out_reg.sv
module csvtok_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load_valid,
   input  csvtok_pkg::rsp_type load_data,
   output logic                load_ready,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output csvtok_pkg::rsp_type rsp_data
);
   import csvtok_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   assign load_ready = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load_ready) begin
         valid_in = load_valid;
         data_in  = load_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

FILE: rtl/csv_quoted_field_tokenizer_unit.sv
// CSV tokenizer: takes one request per cycle (a text byte or end of input) and gives at
// most one token per request, shown in the output register. A request sits in an input
// register while the quote/CR flags and the delimiter compare decide its token, which
// is written to the output register; the flags move on as the request leaves the input
// register, so a new request can be taken every cycle and only a stalled, full output
// register holds the input back. Tokens: content byte, field end, field and row end,
// final field and row, unterminated-quote error. The delimiter register (comma after
// reset) is always ready and must be written only while the unit is empty.
module csv_quoted_field_tokenizer_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  csvtok_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output csvtok_pkg::rsp_type rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [7:0]          csr_wdata
);
   import csvtok_pkg::*;

   logic [7:0] delimiter_ff, delimiter_in;
   logic       s1_valid_ff, s1_valid_in;
   req_type    s1_data_ff, s1_data_in;
   flags_type  flags_ff, flags_in;

   flags_type  flags_next;
   logic       emit;
   rsp_type    step_rsp;
   logic       out_ready;
   logic       s1_go;
   logic       req_take;

   csvtok_step u_step (
      .flags      (flags_ff),
      .delimiter  (delimiter_ff),
      .req        (s1_data_ff),
      .flags_next (flags_next),
      .emit       (emit),
      .rsp        (step_rsp)
   );

   csvtok_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .load_valid (s1_go && emit),
      .load_data  (step_rsp),
      .load_ready (out_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   // a request with no token leaves without waiting for the output side
   assign s1_go     = s1_valid_ff && (out_ready || !emit);
   assign req_stall = s1_valid_ff && !s1_go;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_data_in   = s1_data_ff;
      flags_in     = flags_ff;
      delimiter_in = delimiter_ff;
      if (s1_go) begin
         flags_in    = flags_next;
         s1_valid_in = 1'b0;
      end
      if (req_take) begin
         s1_valid_in = 1'b1;
         s1_data_in  = req_data;
      end
      if (csr_valid && csr_ready) begin
         delimiter_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         flags_ff     <= '0;
         delimiter_ff <= DELIM_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         flags_ff     <= flags_in;
         delimiter_ff <= delimiter_in;
      end
      s1_data_ff <= s1_data_in;
   end

endmodule

FILE: rtl/csvtok_checker.sv
module csvtok_checker (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input csvtok_pkg::rsp_type rsp_data
);
   import csvtok_pkg::*;

   // output side is empty straight after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("token shown straight after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled token changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.token_kind <= KIND_ERROR)
      else $error("token kind out of range");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.token_kind != KIND_CONTENT |-> rsp_data.out_byte == 8'd0)
      else $error("non-content token carries a byte");

endmodule

bind csv_quoted_field_tokenizer_unit csvtok_checker u_csvtok_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
